// ----- src/slpq_pkg.sv -----
// ----------------------------------------------------------------------------
// slpq_pkg
// Shared types, field widths and the microcode table for the sorted-list
// priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slpq_pkg;

    localparam int MODE_W      = 2;
    localparam int ID_W        = 6;
    localparam int RATING_IN_W = 32;
    localparam int STATUS_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        M_CLEAR  = 2'd0,
        M_INSERT = 2'd1,
        M_POP    = 2'd2,
        M_DELETE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // microcode addresses
    typedef enum logic [3:0] {
        STEP_IDLE     = 4'd0,
        STEP_CLR      = 4'd1,
        STEP_INS0     = 4'd2,
        STEP_INS_WALK = 4'd3,
        STEP_INS_LINK = 4'd4,
        STEP_INS_PREV = 4'd5,
        STEP_INS_HEAD = 4'd6,
        STEP_POP0     = 4'd7,
        STEP_POP1     = 4'd8,
        STEP_DEL0     = 4'd9,
        STEP_DEL1     = 4'd10,
        STEP_DEL_HEAD = 4'd11,
        STEP_DEL_WALK = 4'd12,
        STEP_DEL_CHK  = 4'd13,
        STEP_DEL_LINK = 4'd14,
        STEP_FIN      = 4'd15
    } step_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_FULL,
        C_WALK_DONE,
        C_PREV_END,
        C_HEAD_END,
        C_ID_MATCH,
        C_DEL_STOP,
        C_Q_STOP,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {RD_NONE, RD_HEAD, RD_NEXT} rd_sel_t;
    typedef enum logic [1:0] {P_HOLD, P_HEAD, P_NEXT, P_Q} p_sel_t;
    typedef enum logic [1:0] {PV_HOLD, PV_END, PV_P} prev_sel_t;
    typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} cnt_op_t;
    typedef enum logic [1:0] {H_HOLD, H_END, H_USED, H_NEXT} head_sel_t;
    typedef enum logic [1:0] {NW_NONE, NW_USED_P, NW_PREV_USED, NW_P_NEXT} nw_sel_t;

    typedef struct packed {
        cond_t     cond;
        step_t     jmp;
        step_t     nxt;
        logic      dispatch;    // wait for a word, branch on its mode
        logic      hold;        // suppress actions when the jump is taken
        rd_sel_t   rd_sel;
        p_sel_t    p_sel;
        prev_sel_t prev_sel;
        logic      q_load;
        cnt_op_t   steps_op;
        head_sel_t head_sel;
        cnt_op_t   used_op;
        logic      wr_entry;
        nw_sel_t   nw_sel;
        logic      status_set;
        status_t   status_val;
        logic      resid_load;
        logic      out_load;
    } cw_t;

    typedef struct packed {
        logic full;
        logic walk_done;
        logic prev_end;
        logic head_end;
        logic id_match;
        logic del_stop;
        logic q_stop;
        logic out_busy;
    } flags_t;

    function automatic cw_t ucode(step_t s);
        cw_t w;
        begin
            w = '0;
            w.nxt = STEP_FIN;
            case (s)
                STEP_IDLE:
                begin
                    w.dispatch = 1'b1;
                    w.nxt      = STEP_IDLE;
                end
                STEP_CLR:
                begin
                    w.head_sel   = H_END;
                    w.used_op    = CNT_CLR;
                    w.status_set = 1'b1;
                    w.status_val = ST_OK;
                end
                STEP_INS0:
                begin
                    w.cond       = C_FULL;
                    w.jmp        = STEP_FIN;
                    w.nxt        = STEP_INS_WALK;
                    w.status_set = 1'b1;
                    w.status_val = ST_FULL;
                    w.rd_sel     = RD_HEAD;
                    w.p_sel      = P_HEAD;
                    w.prev_sel   = PV_END;
                    w.steps_op   = CNT_CLR;
                    w.wr_entry   = 1'b1;
                end
                STEP_INS_WALK:
                begin
                    w.cond     = C_WALK_DONE;
                    w.jmp      = STEP_INS_LINK;
                    w.nxt      = STEP_INS_WALK;
                    w.hold     = 1'b1;
                    w.rd_sel   = RD_NEXT;
                    w.p_sel    = P_NEXT;
                    w.prev_sel = PV_P;
                    w.steps_op = CNT_INC;
                end
                STEP_INS_LINK:
                begin
                    w.cond   = C_PREV_END;
                    w.jmp    = STEP_INS_HEAD;
                    w.nxt    = STEP_INS_PREV;
                    w.nw_sel = NW_USED_P;
                end
                STEP_INS_PREV:
                begin
                    w.nw_sel     = NW_PREV_USED;
                    w.used_op    = CNT_INC;
                    w.status_set = 1'b1;
                    w.status_val = ST_OK;
                end
                STEP_INS_HEAD:
                begin
                    w.head_sel   = H_USED;
                    w.used_op    = CNT_INC;
                    w.status_set = 1'b1;
                    w.status_val = ST_OK;
                end
                STEP_POP0:
                begin
                    w.cond       = C_HEAD_END;
                    w.jmp        = STEP_FIN;
                    w.nxt        = STEP_POP1;
                    w.status_set = 1'b1;
                    w.status_val = ST_EMPTY;
                    w.rd_sel     = RD_HEAD;
                end
                STEP_POP1:
                begin
                    w.resid_load = 1'b1;
                    w.head_sel   = H_NEXT;
                    w.status_set = 1'b1;
                    w.status_val = ST_OK;
                end
                STEP_DEL0:
                begin
                    w.cond       = C_HEAD_END;
                    w.jmp        = STEP_FIN;
                    w.nxt        = STEP_DEL1;
                    w.status_set = 1'b1;
                    w.status_val = ST_EMPTY;
                    w.rd_sel     = RD_HEAD;
                    w.p_sel      = P_HEAD;
                    w.steps_op   = CNT_CLR;
                end
                STEP_DEL1:
                begin
                    w.cond   = C_ID_MATCH;
                    w.jmp    = STEP_DEL_HEAD;
                    w.nxt    = STEP_DEL_WALK;
                    w.hold   = 1'b1;
                    w.rd_sel = RD_NEXT;
                    w.q_load = 1'b1;
                end
                STEP_DEL_HEAD:
                begin
                    w.head_sel   = H_NEXT;
                    w.status_set = 1'b1;
                    w.status_val = ST_OK;
                end
                STEP_DEL_WALK:
                begin
                    w.cond     = C_DEL_STOP;
                    w.jmp      = STEP_DEL_CHK;
                    w.nxt      = STEP_DEL_WALK;
                    w.hold     = 1'b1;
                    w.rd_sel   = RD_NEXT;
                    w.p_sel    = P_Q;
                    w.q_load   = 1'b1;
                    w.steps_op = CNT_INC;
                end
                STEP_DEL_CHK:
                begin
                    w.cond = C_Q_STOP;
                    w.jmp  = STEP_FIN;
                    w.nxt  = STEP_DEL_LINK;
                end
                STEP_DEL_LINK:
                begin
                    w.nw_sel     = NW_P_NEXT;
                    w.status_set = 1'b1;
                    w.status_val = ST_OK;
                end
                STEP_FIN:
                begin
                    w.cond     = C_OUT_BUSY;
                    w.jmp      = STEP_FIN;
                    w.nxt      = STEP_IDLE;
                    w.hold     = 1'b1;
                    w.out_load = 1'b1;
                end
                default:
                begin
                    w.nxt = STEP_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

// ----- src/sorted_list_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_list_priority_queue: linked-list priority queue, best rating first
// One word at a time; the result turns valid as the sequencer returns to take the next word.
// Insert and delete walk the list one node per cycle; a stalled result holds the sequencer.
// Reset empties the list (head at end marker, no slots used); no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_priority_queue
#(
    parameter int SLOTS       = 64,
    parameter int RATING_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [slpq_pkg::MODE_W-1:0]         mode,
    input  logic [slpq_pkg::ID_W-1:0]           expert_id,
    input  logic signed [slpq_pkg::RATING_IN_W-1:0] rating,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [slpq_pkg::ID_W-1:0]           result_id,
    output logic [slpq_pkg::STATUS_W-1:0]       status
);
    import slpq_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] END_PTR = PW'(SLOTS);
    localparam logic [RATING_BITS-1:0] SIGN_BIT = {1'b1, {(RATING_BITS-1){1'b0}}};

    cw_t    cw;
    logic   act;
    flags_t flags;
    logic   accept;

    // slot memories
    logic [ID_W-1:0]        mem_id   [SLOTS];
    logic [RATING_BITS-1:0] mem_key  [SLOTS];
    logic [PW-1:0]          mem_next [SLOTS];
    logic [ID_W-1:0]        rd_id_reg;
    logic [RATING_BITS-1:0] rd_key_reg;
    logic [PW-1:0]          rd_next_reg;

    // control state
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] used_reg, used_next;
    logic          out_valid_reg, out_valid_next;

    // working registers
    logic [PW-1:0]          p_reg, p_next;
    logic [PW-1:0]          prev_reg, prev_next;
    logic [PW-1:0]          q_reg, q_next;
    logic [PW-1:0]          steps_reg, steps_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [RATING_BITS-1:0] key_reg, key_next;
    status_t                status_reg, status_next;
    logic [ID_W-1:0]        resid_reg, resid_next;
    logic [ID_W-1:0]        result_id_reg;
    status_t                status_out_reg;

    logic          rd_en;
    logic [PW-1:0] rd_ptr;
    logic          entry_we;
    logic          nx_we;
    logic [PW-1:0] nx_ptr;
    logic [PW-1:0] nx_data;
    logic          out_fire;
    logic          p_end;
    logic          q_end;
    logic          steps_max;
    logic          gt;

    slpq_useq u_useq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode_t'(mode)),
        .flags    (flags),
        .cw       (cw),
        .act      (act)
    );

    assign in_ready  = cw.dispatch;
    assign accept    = in_valid && cw.dispatch;
    assign out_valid = out_valid_reg;
    assign result_id = result_id_reg;
    assign status    = status_out_reg;

    // condition flags
    always_comb
    begin
        p_end     = p_reg >= END_PTR;
        q_end     = q_reg >= END_PTR;
        steps_max = steps_reg >= END_PTR;
        gt        = rd_key_reg > key_reg;

        flags.full      = used_reg >= END_PTR;
        flags.walk_done = p_end || steps_max || !gt;
        flags.prev_end  = prev_reg >= END_PTR;
        flags.head_end  = head_reg >= END_PTR;
        flags.id_match  = rd_id_reg == id_reg;
        flags.q_stop    = steps_max || q_end;
        flags.del_stop  = steps_max || q_end || (rd_id_reg == id_reg);
        flags.out_busy  = out_valid_reg && !out_ready;
    end

    // memory controls
    always_comb
    begin
        rd_en    = act && (cw.rd_sel != RD_NONE);
        rd_ptr   = (cw.rd_sel == RD_HEAD) ? head_reg : rd_next_reg;
        entry_we = act && cw.wr_entry && !flags.full;
        nx_we    = act && (cw.nw_sel != NW_NONE);
        case (cw.nw_sel)
            NW_USED_P:
            begin
                nx_ptr  = used_reg;
                nx_data = p_end ? END_PTR : p_reg;
            end
            NW_PREV_USED:
            begin
                nx_ptr  = prev_reg;
                nx_data = used_reg;
            end
            NW_P_NEXT:
            begin
                nx_ptr  = p_reg;
                nx_data = rd_next_reg;
            end
            default:
            begin
                nx_ptr  = used_reg;
                nx_data = p_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            mem_id[used_reg[SW-1:0]]  <= id_reg;
            mem_key[used_reg[SW-1:0]] <= key_reg;
        end
        if (nx_we)
        begin
            mem_next[nx_ptr[SW-1:0]] <= nx_data;
        end
        if (rd_en)
        begin
            rd_id_reg   <= mem_id[rd_ptr[SW-1:0]];
            rd_key_reg  <= mem_key[rd_ptr[SW-1:0]];
            rd_next_reg <= mem_next[rd_ptr[SW-1:0]];
        end
    end

    // datapath next values
    always_comb
    begin
        head_next   = head_reg;
        used_next   = used_reg;
        p_next      = p_reg;
        prev_next   = prev_reg;
        q_next      = q_reg;
        steps_next  = steps_reg;
        status_next = status_reg;
        resid_next  = resid_reg;
        id_next     = id_reg;
        key_next    = key_reg;
        out_fire    = act && cw.out_load;

        if (accept)
        begin
            id_next    = expert_id;
            // flip the sign bit so an unsigned compare orders signed ratings
            key_next   = RATING_BITS'($unsigned(rating)) ^ SIGN_BIT;
            resid_next = '0;
        end

        if (act)
        begin
            case (cw.p_sel)
                P_HEAD:  p_next = head_reg;
                P_NEXT:  p_next = rd_next_reg;
                P_Q:     p_next = q_reg;
                default: p_next = p_reg;
            endcase
            case (cw.prev_sel)
                PV_END:  prev_next = END_PTR;
                PV_P:    prev_next = p_reg;
                default: prev_next = prev_reg;
            endcase
            if (cw.q_load)
            begin
                q_next = rd_next_reg;
            end
            case (cw.steps_op)
                CNT_CLR: steps_next = '0;
                CNT_INC: steps_next = steps_reg + 1'b1;
                default: steps_next = steps_reg;
            endcase
            case (cw.head_sel)
                H_END:   head_next = END_PTR;
                H_USED:  head_next = used_reg;
                H_NEXT:  head_next = rd_next_reg;
                default: head_next = head_reg;
            endcase
            case (cw.used_op)
                CNT_CLR: used_next = '0;
                CNT_INC: used_next = used_reg + 1'b1;
                default: used_next = used_reg;
            endcase
            if (cw.status_set)
            begin
                status_next = cw.status_val;
            end
            if (cw.resid_load)
            begin
                resid_next = rd_id_reg;
            end
        end

        if (out_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= END_PTR;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        prev_reg   <= prev_next;
        q_reg      <= q_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        resid_reg  <= resid_next;
        id_reg     <= id_next;
        key_reg    <= key_next;
        if (out_fire)
        begin
            result_id_reg  <= resid_reg;
            status_out_reg <= status_reg;
        end
    end

    // sequencer leaves the dispatch step once a word is taken
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer still ready after accepting a word");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= END_PTR)
        else $error("slot count beyond capacity");

    // head is either the end marker or a slot already handed out
    a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == END_PTR) || (head_reg < used_reg))
        else $error("head points at an unused slot");

    a_resid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (result_id == '0))
        else $error("nonzero id on a failed operation");

endmodule

// ----- src/slpq_useq.sv -----
// ----------------------------------------------------------------------------
// slpq_useq
// Microcode sequencer: step counter, control word table, conditional jumps
// and the mode dispatch on an accepted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slpq_useq
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  slpq_pkg::mode_t mode,
    input  slpq_pkg::flags_t flags,
    output slpq_pkg::cw_t   cw,
    output logic            act
);
    import slpq_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    logic  take;

    assign cw = ucode(upc_reg);

    always_comb
    begin
        case (cw.cond)
            C_NEVER:     take = 1'b0;
            C_FULL:      take = flags.full;
            C_WALK_DONE: take = flags.walk_done;
            C_PREV_END:  take = flags.prev_end;
            C_HEAD_END:  take = flags.head_end;
            C_ID_MATCH:  take = flags.id_match;
            C_DEL_STOP:  take = flags.del_stop;
            C_Q_STOP:    take = flags.q_stop;
            C_OUT_BUSY:  take = flags.out_busy;
            default:     take = 1'b0;
        endcase

        act = !(cw.hold && take);

        if (cw.dispatch)
        begin
            if (in_valid)
            begin
                case (mode)
                    M_CLEAR:  upc_next = STEP_CLR;
                    M_INSERT: upc_next = STEP_INS0;
                    M_POP:    upc_next = STEP_POP0;
                    M_DELETE: upc_next = STEP_DEL0;
                    default:  upc_next = STEP_IDLE;
                endcase
            end
            else
            begin
                upc_next = STEP_IDLE;
            end
        end
        else if (take)
        begin
            upc_next = cw.jmp;
        end
        else
        begin
            upc_next = cw.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: sorted_list_priority_queue
// Drives clear, insert, pop and delete words with random gaps on both sides.
// A tracker class keeps its own copy of the rating list and checks every
// returned word, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import slpq_pkg::*;

    localparam int SLOTS    = 64;
    localparam int END_SLOT = SLOTS;
    localparam int N_RANDOM = 1350;

    typedef struct {
        logic [ID_W-1:0] id;
        status_t         st;
    } outcome_t;

    class list_tracker;
        logic [ID_W-1:0]        ids[SLOTS];
        logic signed [31:0]     rates[SLOTS];
        int                     links[SLOTS];
        int                     head;
        int                     used;
        outcome_t               outcomes[$];
        int                     errors;

        function new();
            head   = END_SLOT;
            used   = 0;
            errors = 0;
        endfunction

        task report(string what);
            errors++;
            // keep the log short on a broken build
            if (errors <= 40)
                $display("%0t mismatch: %s", $time, what);
        endtask

        function int pending();
            return outcomes.size();
        endfunction

        // id of a random entry still on the list, -1 when empty
        function int pick_live();
            int n;
            int p;
            int k;
            n = 0;
            p = head;
            while (p < SLOTS && n < SLOTS)
            begin
                n++;
                p = links[p];
            end
            if (n == 0)
                return -1;
            k = $urandom_range(0, n - 1);
            p = head;
            repeat (k) p = links[p];
            return int'(ids[p]);
        endfunction

        function void note_word(mode_t m, logic [ID_W-1:0] id, logic signed [31:0] r);
            outcome_t o;
            int       slot;
            int       p;
            int       q;
            int       prev;
            int       steps;
            o.id = '0;
            o.st = ST_OK;
            case (m)
                M_CLEAR:
                begin
                    head = END_SLOT;
                    used = 0;
                end
                M_INSERT:
                begin
                    if (used >= SLOTS)
                        o.st = ST_FULL;
                    else
                    begin
                        slot        = used;
                        ids[slot]   = id;
                        rates[slot] = r;
                        prev        = END_SLOT;
                        p           = head;
                        steps       = 0;
                        // stop at first entry not greater: newer wins ties
                        while (p < SLOTS && steps < SLOTS && rates[p] > r)
                        begin
                            prev = p;
                            p    = links[p];
                            steps++;
                        end
                        links[slot] = (p >= SLOTS) ? END_SLOT : p;
                        if (prev == END_SLOT)
                            head = slot;
                        else
                            links[prev] = slot;
                        used = slot + 1;
                    end
                end
                M_POP:
                begin
                    if (head >= SLOTS)
                        o.st = ST_EMPTY;
                    else
                    begin
                        o.id = ids[head];
                        head = links[head];
                    end
                end
                default:
                begin
                    if (head >= SLOTS)
                        o.st = ST_EMPTY;
                    else if (ids[head] == id)
                        head = links[head];
                    else
                    begin
                        o.st  = ST_EMPTY;
                        p     = head;
                        steps = 0;
                        while (steps < SLOTS)
                        begin
                            q = links[p];
                            if (q >= SLOTS)
                                break;
                            if (ids[q] == id)
                            begin
                                links[p] = links[q];
                                o.st     = ST_OK;
                                break;
                            end
                            p = q;
                            steps++;
                        end
                    end
                end
            endcase
            outcomes.push_back(o);
        endfunction

        task check_result(logic [ID_W-1:0] rid, logic [STATUS_W-1:0] st);
            outcome_t o;
            if (outcomes.size() == 0)
                report($sformatf("unexpected word id=%0d status=%0d", rid, st));
            else
            begin
                o = outcomes.pop_front();
                if (rid !== o.id)
                    report($sformatf("result_id %0d, want %0d", rid, o.id));
                if (st !== o.st)
                    report($sformatf("status %0d, want %0d", st, o.st));
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    mode_t                  mode = M_CLEAR;
    logic [ID_W-1:0]        expert_id = '0;
    logic signed [31:0]     rating = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [ID_W-1:0]        result_id;
    logic [STATUS_W-1:0]    status;

    list_tracker            sb;
    bit                     calm = 1'b0;

    sorted_list_priority_queue dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .expert_id (expert_id),
        .rating    (rating),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result_id (result_id),
        .status    (status)
    );

    always #4 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int gap_len();
        int w;
        if (calm)
            return 0;
        w = $urandom_range(0, 99);
        if (w < 50)
            return 0;
        if (w < 85)
            return $urandom_range(1, 3);
        if (w < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_rating(int kind);
        int w;
        w = $urandom_range(0, 9);
        // kind 1 only uses a few values so ties are common
        if (kind == 1 || (kind == 2 && w < 3))
        begin
            case ($urandom_range(0, 5))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h0000_0001;
                default: return 32'h0001_0000;
            endcase
        end
        return $urandom;
    endfunction

    // caller sits at a rising edge; returns at the edge that took the word
    task automatic send_word(mode_t m, logic [ID_W-1:0] id, logic [31:0] r);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        expert_id <= id;
        rating    <= r;
        do @(posedge clk); while (!in_ready);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_word(mode, expert_id, rating);
            if (out_valid && out_ready)
                sb.check_result(result_id, status);
        end
    end

    initial
    begin
        int g;
        int hold;
        wait (rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            hold = $urandom_range(1, 10);
            repeat (hold) @(posedge clk);
        end
    end

    initial
    begin
        int    total;
        int    len;
        int    i;
        int    w;
        int    live;
        int    rkind;
        bit    fill;
        bit    narrow;
        mode_t m;
        logic [ID_W-1:0] id;

        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list cases
        send_word(M_POP,    6'd0,  32'h0);
        send_word(M_DELETE, 6'd0,  32'h0);
        // extremes, a tie and a duplicate id
        send_word(M_INSERT, 6'd0,  32'h0000_0000);
        send_word(M_INSERT, 6'd63, 32'h7FFF_FFFF);
        send_word(M_INSERT, 6'd5,  32'h8000_0000);
        send_word(M_INSERT, 6'd7,  32'h0000_0000);
        send_word(M_INSERT, 6'd7,  32'hFFFF_FFFF);
        send_word(M_DELETE, 6'd7,  32'h0);
        send_word(M_DELETE, 6'd63, 32'h0);
        send_word(M_DELETE, 6'd40, 32'h0);
        send_word(M_POP,    6'd0,  32'h0);
        send_word(M_POP,    6'd0,  32'h0);
        send_word(M_POP,    6'd0,  32'h0);
        send_word(M_POP,    6'd0,  32'h0);
        send_word(M_INSERT, 6'd1,  32'h0001_0000);
        send_word(M_INSERT, 6'd2,  32'h8000_0001);
        send_word(M_INSERT, 6'd3,  32'h7FFF_FFFE);
        send_word(M_CLEAR,  6'd63, 32'hFFFF_FFFF);
        send_word(M_POP,    6'd0,  32'h0);
        send_word(M_INSERT, 6'd63, 32'hFFFF_FFFF);
        send_word(M_DELETE, 6'd63, 32'h0);
        send_word(M_DELETE, 6'd63, 32'h0);

        total = 0;
        while (total < N_RANDOM)
        begin
            fill   = ($urandom_range(0, 3) == 0);
            narrow = ($urandom_range(0, 2) == 0);
            rkind  = $urandom_range(0, 2);
            calm   = ($urandom_range(0, 4) == 0);
            len    = fill ? $urandom_range(70, 120) : $urandom_range(20, 150);
            if ($urandom_range(0, 1))
            begin
                send_word(M_CLEAR, 6'($urandom_range(0, 63)), $urandom);
                total++;
            end
            for (i = 0; i < len && total < N_RANDOM; i++)
            begin
                w = $urandom_range(0, 99);
                if (fill)
                    m = (w < 90) ? M_INSERT : (w < 94) ? M_POP : (w < 99) ? M_DELETE : M_CLEAR;
                else
                    m = (w < 45) ? M_INSERT : (w < 70) ? M_POP : (w < 98) ? M_DELETE : M_CLEAR;
                id = narrow ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
                if (m == M_DELETE && $urandom_range(0, 9) < 6)
                begin
                    live = sb.pick_live();
                    if (live >= 0)
                        id = 6'(live);
                end
                send_word(m, id, pick_rating(rkind));
                total++;
            end
        end
        in_valid <= 1'b0;
        // let the last accepted word be noted before counting what is left
        @(posedge clk);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/slpq_pkg.sv
src/slpq_useq.sv
src/sorted_list_priority_queue.sv
tb/testbench.sv
